### sv/vctf_pkg.sv
// vctf_pkg: shared types and codes for the vertex component to float converter
// no dependencies; imported by vctf_d2s, vertex_component_to_float_top and its bench
`default_nettype none

package vctf_pkg;

   localparam logic [2:0] FMT_FLOAT  = 3'd0;
   localparam logic [2:0] FMT_DOUBLE = 3'd1;
   localparam logic [2:0] FMT_S8     = 3'd2;
   localparam logic [2:0] FMT_S16    = 3'd3;
   localparam logic [2:0] FMT_S32    = 3'd4;
   localparam logic [2:0] FMT_U8     = 3'd5;
   localparam logic [2:0] FMT_U16    = 3'd6;
   localparam logic [2:0] FMT_U32    = 3'd7;

   // integer width class
   typedef enum logic [1:0] {
      BW_8  = 2'd0,
      BW_16 = 2'd1,
      BW_32 = 2'd2
   } bw_type;

   // how a beat gets its double-precision image
   typedef enum logic [2:0] {
      K_PASS = 3'd0,
      K_DBL  = 3'd1,
      K_INT  = 3'd2,
      K_NORM = 3'd3,
      K_ONE  = 3'd4,
      K_ZERO = 3'd5
   } kind_type;

   // beat handed to the double to single rounder
   typedef struct packed {
      logic        valid;
      logic        bypass;
      logic [63:0] word;
   } d2s_beat_type;

endpackage

`default_nettype wire

### sv/vertex_component_to_float_top.sv
// vertex_component_to_float_top: vertex attribute component to ieee single
// depends on vctf_pkg and vctf_d2s
//
//   channel | ports                                      | dir
//   req     | req_valid req_stall req_raw_bits req_format req_normalize | in
//   rsp     | rsp_valid rsp_stall rsp_float_bits         | out
//
// five register stages: decode, leading zero count, double image, align, round
// one beat per cycle while no valid output beat is held by rsp_stall; rsp_valid is the round stage valid bit
// all stages move together; req_stall rises only when the output beat is held
// reset clears the stage valid bits only, payload registers are not reset
`default_nettype none

module vertex_component_to_float_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_raw_bits,
   input  wire  [2:0]  req_format,
   input  wire         req_normalize,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_float_bits
);
   import vctf_pkg::*;

   logic advance;

   // stage 1: decode
   logic        s1_valid_ff;
   kind_type    s1_kind_ff, s1_kind_in;
   bw_type      s1_bw_ff, s1_bw_in;
   logic        s1_sign_ff, s1_sign_in;
   logic [31:0] s1_mag_ff, s1_mag_in;
   logic [63:0] s1_raw_ff;

   // stage 2: leading zeros
   logic        s2_valid_ff;
   kind_type    s2_kind_ff;
   bw_type      s2_bw_ff;
   logic        s2_sign_ff;
   logic [31:0] s2_mag_ff;
   logic [63:0] s2_raw_ff;
   logic [4:0]  s2_lz_ff, s2_lz_in;

   // stage 3: double image
   d2s_beat_type s3_beat_ff, s3_beat_in;

   logic [31:0] x, xs, mask, nm;
   logic        is_signed, neg;

   always_comb begin
      is_signed = req_format inside {FMT_S8, FMT_S16, FMT_S32};
      case (req_format)
         FMT_S8, FMT_U8:   s1_bw_in = BW_8;
         FMT_S16, FMT_U16: s1_bw_in = BW_16;
         default:          s1_bw_in = BW_32;
      endcase
      case (s1_bw_in)
         BW_8: begin
            x    = {24'd0, req_raw_bits[7:0]};
            mask = 32'h0000_00FF;
            neg  = is_signed & req_raw_bits[7];
         end
         BW_16: begin
            x    = {16'd0, req_raw_bits[15:0]};
            mask = 32'h0000_FFFF;
            neg  = is_signed & req_raw_bits[15];
         end
         default: begin
            x    = req_raw_bits[31:0];
            mask = 32'hFFFF_FFFF;
            neg  = is_signed & req_raw_bits[31];
         end
      endcase
      xs = x | ({32{neg}} & ~mask);
      // |2v+1| for negative v is {~v,1}
      nm = (((x ^ {32{neg}}) << 1) | 32'd1) & mask;

      s1_sign_in = neg;
      s1_mag_in  = 32'd0;
      if (req_format == FMT_FLOAT) begin
         s1_kind_in = K_PASS;
      end else if (req_format == FMT_DOUBLE) begin
         s1_kind_in = K_DBL;
      end else if (req_normalize) begin
         s1_mag_in = is_signed ? nm : x;
         if (s1_mag_in == mask) begin
            s1_kind_in = K_ONE;
         end else if (s1_mag_in == 32'd0) begin
            s1_kind_in = K_ZERO;
         end else begin
            s1_kind_in = K_NORM;
         end
      end else begin
         s1_mag_in  = neg ? (~xs + 32'd1) : x;
         s1_kind_in = (s1_mag_in == 32'd0) ? K_ZERO : K_INT;
      end
   end

   always_comb begin
      s2_lz_in = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (s1_mag_ff[i]) begin
            s2_lz_in = 5'(31 - i);
         end
      end
   end

   logic [4:0]   lzb;
   logic [127:0] rep, rsh;
   logic [53:0]  top54;
   logic [53:0]  msum;
   logic [31:0]  ish;
   logic [10:0]  nexp;

   always_comb begin
      case (s2_bw_ff)
         BW_8: begin
            lzb = s2_lz_ff - 5'd24;
            rep = {16{s2_mag_ff[7:0]}};
         end
         BW_16: begin
            lzb = s2_lz_ff - 5'd16;
            rep = {8{s2_mag_ff[15:0]}};
         end
         default: begin
            lzb = s2_lz_ff;
            rep = {4{s2_mag_ff}};
         end
      endcase
      // quotient by 2^b-1 repeats the b-bit block forever, so sticky is set
      rsh   = rep << lzb;
      top54 = rsh[127:74];
      msum  = {1'b0, top54[53:1]} + {53'd0, top54[0]};
      nexp  = 11'd1022 - {6'd0, lzb} + {10'd0, msum[53]};
      ish   = s2_mag_ff << s2_lz_ff;

      s3_beat_in.valid  = s2_valid_ff;
      s3_beat_in.bypass = 1'b0;
      case (s2_kind_ff)
         K_PASS: begin
            s3_beat_in.bypass = 1'b1;
            s3_beat_in.word   = {32'd0, s2_raw_ff[31:0]};
         end
         K_DBL:  s3_beat_in.word = s2_raw_ff;
         K_INT:  s3_beat_in.word = {s2_sign_ff, 11'd1054 - {6'd0, s2_lz_ff},
                                    ish[30:0], 21'd0};
         K_NORM: s3_beat_in.word = {s2_sign_ff, nexp,
                                    msum[53] ? 52'd0 : msum[51:0]};
         K_ONE:  s3_beat_in.word = {s2_sign_ff, 11'h3FF, 52'd0};
         default: s3_beat_in.word = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_beat_ff.valid  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff       <= req_valid;
         s2_valid_ff       <= s1_valid_ff;
         s3_beat_ff.valid  <= s3_beat_in.valid;
      end
      if (advance) begin
         s1_kind_ff        <= s1_kind_in;
         s1_bw_ff          <= s1_bw_in;
         s1_sign_ff        <= s1_sign_in;
         s1_mag_ff         <= s1_mag_in;
         s1_raw_ff         <= req_raw_bits;
         s2_kind_ff        <= s1_kind_ff;
         s2_bw_ff          <= s1_bw_ff;
         s2_sign_ff        <= s1_sign_ff;
         s2_mag_ff         <= s1_mag_ff;
         s2_raw_ff         <= s1_raw_ff;
         s2_lz_ff          <= s2_lz_in;
         s3_beat_ff.bypass <= s3_beat_in.bypass;
         s3_beat_ff.word   <= s3_beat_in.word;
      end
   end

   vctf_d2s u_d2s (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .beat      (s3_beat_ff),
      .out_valid (rsp_valid),
      .out_bits  (rsp_float_bits)
   );

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   a_stall_only_on_held_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("stall without a held output beat");

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !req_stall) |=> s2_valid_ff) else $error("beat lost after decode");

   a_s2_to_s3: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !req_stall) |=> s3_beat_ff.valid) else $error("beat lost after lzc");

   a_frozen_s3: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(s3_beat_ff)) else $error("stage 3 moved under stall");

endmodule

`default_nettype wire

### sv/vctf_d2s.sv
// vctf_d2s: two-stage round of an ieee double pattern to single, nearest-even
// depends on vctf_pkg; a bypass beat carries a finished single in word[31:0]
`default_nettype none

module vctf_d2s (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  vctf_pkg::d2s_beat_type beat,
   output logic                  out_valid,
   output logic [31:0]           out_bits
);
   import vctf_pkg::*;

   logic        s4_valid_ff;
   logic        s4_sign_ff, s4_sign_in;
   logic [30:0] s4_r_ff, s4_r_in;
   logic        s4_inc_ff, s4_inc_in;
   logic        s5_valid_ff;
   logic [31:0] s5_bits_ff;

   logic [10:0] e;
   logic [51:0] m;
   logic [63:0] full;
   logic [5:0]  s;
   logic [5:0]  sm1;
   logic [63:0] keep;
   logic        g;
   logic        sticky;

   always_comb begin
      e    = beat.word[62:52];
      m    = beat.word[51:0];
      full = {11'd0, 1'b1, m};
      if (e >= 11'd897) begin
         s = 6'd29;
      end else begin
         s = 6'(11'd926 - e);
      end
      sm1    = s - 6'd1;
      keep   = full >> s;
      g      = full[sm1];
      sticky = |(full & ((64'd1 << sm1) - 64'd1));

      s4_sign_in = beat.word[63];
      s4_r_in    = 31'd0;
      s4_inc_in  = 1'b0;
      if (beat.bypass) begin
         s4_sign_in = beat.word[31];
         s4_r_in    = beat.word[30:0];
      end else if (e == 11'h7FF) begin
         if (m != 52'd0) begin
            s4_r_in = {8'hFF, 1'b1, m[50:29]};
         end else begin
            s4_r_in = {8'hFF, 23'd0};
         end
      end else if (e == 11'd0) begin
         s4_r_in = 31'd0;
      end else if (e >= 11'd1151) begin
         s4_r_in = {8'hFF, 23'd0};
      end else if (e >= 11'd897) begin
         s4_r_in   = {8'(e - 11'd896), keep[22:0]};
         s4_inc_in = g & (sticky | keep[0]);
      end else if (e < 11'd873) begin
         s4_r_in = 31'd0;
      end else begin
         s4_r_in   = keep[30:0];
         s4_inc_in = g & (sticky | keep[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= beat.valid;
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s4_sign_ff <= s4_sign_in;
         s4_r_ff    <= s4_r_in;
         s4_inc_ff  <= s4_inc_in;
         // carry may run into the exponent, up to infinity
         s5_bits_ff <= {s4_sign_ff, s4_r_ff + {30'd0, s4_inc_ff}};
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_bits  = s5_bits_ff;

endmodule

`default_nettype wire

### test/vertex_component_to_float_top_tb.sv
// vertex_component_to_float_top_tb: self-checking bench for the component to float converter
// depends on vctf_pkg and vertex_component_to_float_top; predicts each float from the raw beat
// using double arithmetic and its own double to single rounding
`default_nettype none

module vertex_component_to_float_top_tb;
   import vctf_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 150;

   typedef struct {
      logic [63:0] raw;
      logic [2:0]  fmt;
      logic        norm;
      int          gap_cycles;
      bit          drain_first;
   } component_type;

   typedef struct {
      logic [63:0] raw;
      logic [2:0]  fmt;
      logic        norm;
      logic [31:0] float_bits;
   } float_expect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_raw_bits = '0;
   logic [2:0]  req_format = FMT_FLOAT;
   logic        req_normalize = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_float_bits;

   component_type    pending_beats[$];
   float_expect_type expected_floats[$];
   int               send_gap = 0;
   int               rsp_wait = 0;
   bit               rsp_hold = 1'b0;
   int               sent_count = 0;
   int               recv_count = 0;
   int               mismatch_count = 0;
   int               idle_cycles = 0;

   vertex_component_to_float_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_raw_bits   (req_raw_bits),
      .req_format     (req_format),
      .req_normalize  (req_normalize),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_float_bits (rsp_float_bits)
   );

   always #5 clock = ~clock;

   // round a double bit pattern to single, nearest-even
   function automatic logic [31:0] round_to_single(logic [63:0] d);
      logic [31:0] sgn;
      int          e;
      int          ex;
      int          sh;
      logic [63:0] full;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] r;
      sgn = {d[63], 31'd0};
      e   = int'(d[62:52]);
      if (e == 2047) begin
         if (d[51:0] != 0) return sgn | 32'h7FC0_0000 | {10'd0, d[50:29]};
         return sgn | 32'h7F80_0000;
      end
      if (e == 0) return sgn;
      ex = e - 896;
      if (ex >= 255) return sgn | 32'h7F80_0000;
      full = {11'd0, 1'b1, d[51:0]};
      if (ex >= 1) sh = 29;
      else begin
         sh = 926 - e;
         if (sh >= 54) return sgn;
      end
      kept = full >> sh;
      rem  = full & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (ex >= 1) r = {1'b0, ex[7:0], kept[22:0]};
      else r = kept[31:0];
      if (rem > half || (rem == half && kept[0])) r = r + 32'd1;
      return sgn | r;
   endfunction

   function automatic logic [31:0] convert_component(logic [63:0] raw, logic [2:0] fmt,
                                                     logic norm);
      longint sv;
      real    den;
      real    q;
      den = 255.0;
      sv  = 0;
      case (fmt)
         FMT_FLOAT:  return raw[31:0];
         FMT_DOUBLE: return round_to_single(raw);
         FMT_S8:  begin sv = $signed(raw[7:0]);  den = 255.0; end
         FMT_S16: begin sv = $signed(raw[15:0]); den = 65535.0; end
         FMT_S32: begin sv = $signed(raw[31:0]); den = 4294967295.0; end
         FMT_U8:  begin sv = longint'(raw[7:0]);  den = 255.0; end
         FMT_U16: begin sv = longint'(raw[15:0]); den = 65535.0; end
         default: begin sv = longint'(raw[31:0]); den = 4294967295.0; end
      endcase
      if (!norm) q = real'(sv);
      else if (fmt inside {FMT_S8, FMT_S16, FMT_S32})
         q = (2.0 * real'(sv) + 1.0) / den;
      else q = real'(sv) / den;
      return round_to_single($realtobits(q));
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] d;
      d = {$urandom, $urandom};
      // mostly exponents around the single range so rounding paths get exercised
      if ($urandom_range(0, 3) != 0) d[62:52] = 11'($urandom_range(850, 1160));
      return d;
   endfunction

   task automatic add_component(logic [63:0] raw, logic [2:0] fmt, logic norm, int gap,
                                bit drain);
      component_type c;
      c.raw = raw;
      c.fmt = fmt;
      c.norm = norm;
      c.gap_cycles = gap;
      c.drain_first = drain;
      pending_beats.push_back(c);
   endtask

   // driver
   always @(posedge clock) begin
      logic             nv;
      int               g;
      component_type    c;
      float_expect_type x;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         nv = req_valid;
         g  = send_gap;
         if (req_valid && !req_stall) begin
            x.raw = req_raw_bits;
            x.fmt = req_format;
            x.norm = req_normalize;
            x.float_bits = convert_component(req_raw_bits, req_format, req_normalize);
            expected_floats.push_back(x);
            sent_count++;
            nv = 1'b0;
            g = (pending_beats.size() > 0) ? pending_beats[0].gap_cycles : 0;
         end
         if (!nv) begin
            if (g > 0) g--;
            else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].drain_first && expected_floats.size() != 0)) begin
               c = pending_beats.pop_front();
               req_raw_bits  <= c.raw;
               req_format    <= c.fmt;
               req_normalize <= c.norm;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
         send_gap  <= g;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      int               w;
      float_expect_type x;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         w = rsp_wait;
         if (rsp_valid && !rsp_stall) begin
            recv_count++;
            if (expected_floats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected beat: float_bits %h", rsp_float_bits);
            end else begin
               x = expected_floats.pop_front();
               if (rsp_float_bits !== x.float_bits) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch raw %h fmt %0d norm %0d: expected %h actual %h",
                              x.raw, x.fmt, x.norm, x.float_bits, rsp_float_bits);
               end
            end
            // every third block of 200 results runs without stalls
            w = ((recv_count / 200) % 3 == 1) ? 0 : $urandom_range(0, 14);
         end else if (w > 0) w--;
         rsp_wait  <= w;
         rsp_stall <= rsp_hold || (w > 0);
      end
   end

   // long receiver hold so the pipe fills and pushes back on req
   initial begin
      while (sent_count < 400) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("vertex_component_to_float_top test failed");
         $finish;
      end
   end

   initial begin
      logic [2:0]  f;
      logic [63:0] r;
      int          gap;
      // float passthrough, signaling nan with junk above bit 31
      add_component(64'hDEAD_BEEF_7F80_0001, FMT_FLOAT, 1'b1, 0, 0);
      add_component(64'h0000_0000_FFFF_FFFF, FMT_FLOAT, 1'b0, 0, 0);
      // double: nan, infinities, overflow, rounding to inf, underflow, subnormals
      add_component(64'hFFF8_0000_2000_0001, FMT_DOUBLE, 1'b1, 0, 0);
      add_component(64'h7FF0_0000_0000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'hFFF0_0000_0000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h47F0_0000_0000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'hC7EF_FFFF_F000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h3690_0000_0000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h36A0_0000_0000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h3690_0000_0000_0001, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h8000_0000_0000_0001, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h3FF0_0000_1000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      add_component(64'h3FF0_0000_3000_0000, FMT_DOUBLE, 1'b0, 0, 0);
      // integer extremes with junk in the unused high bits, both normalize modes
      for (int n = 0; n < 2; n++) begin
         add_component(64'hFFFF_FFFF_FFFF_FF80, FMT_S8,  n[0], 0, 0);
         add_component(64'hAAAA_AAAA_AAAA_007F, FMT_S8,  n[0], 0, 0);
         add_component(64'h5555_5555_5555_8000, FMT_S16, n[0], 0, 0);
         add_component(64'h1234_5678_8000_0000, FMT_S32, n[0], 0, 0);
         add_component(64'hFFFF_FFFF_7FFF_FFFF, FMT_S32, n[0], 0, 0);
         add_component(64'hFFFF_FFFF_FFFF_FFFF, FMT_U8,  n[0], 0, 0);
         add_component(64'hFFFF_FFFF_FFFF_FFFF, FMT_U16, n[0], 0, 0);
         add_component(64'hFFFF_FFFF_FFFF_FFFF, FMT_U32, n[0], 0, 0);
      end
      for (int i = 0; i < 1500; i++) begin
         f = 3'($urandom_range(0, 7));
         r = (f == FMT_DOUBLE) ? random_double() : {$urandom, $urandom};
         // small magnitudes too, so zero and near-zero integers turn up
         if (f != FMT_DOUBLE && $urandom_range(0, 7) == 0) r[31:4] = {28{r[31]}};
         gap = ((i / 150) % 3 == 2) ? 0 : $urandom_range(0, 14);
         add_component(r, f, 1'($urandom), gap, (i == 200 || i == 900));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_beats.size() > 0 || req_valid) @(posedge clock);
      while (expected_floats.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_floats.size() == 0)
         $display("vertex_component_to_float_top test passed");
      else
         $display("vertex_component_to_float_top test failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
sv/vctf_pkg.sv
sv/vctf_d2s.sv
sv/vertex_component_to_float_top.sv
test/vertex_component_to_float_top_tb.sv
